// File: rtl/core/ipv4_dotted_quad_check_macros.svh
// Assertion macros shared by the dotted-quad checker.
`ifndef IPV4_DOTTED_QUAD_CHECK_MACROS_SVH
`define IPV4_DOTTED_QUAD_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPV4Q_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPV4Q_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ipv4q_pkg.sv
// Types and constants for the dotted-quad address checker.
package ipv4q_pkg;

	localparam int CH_W  = 8;
	localparam int LEN_W = 5;
	localparam int POS_W = 4;
	localparam int VAL_W = 10;

	localparam logic [CH_W-1:0]  CH_DOT    = 8'h2E;
	localparam logic [CH_W-1:0]  CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0]  CH_NINE   = 8'h39;
	localparam logic [VAL_W-1:0] OCTET_MAX = 10'd255;
	localparam logic [2:0]       LAST_OCTET = 3'd3;
	localparam logic [1:0]       MAX_DIGITS = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} char_t;

	typedef struct packed {
		logic             is_address;
		logic [LEN_W-1:0] scanned_length;
	} result_t;

endpackage

// File: rtl/core/ipv4q_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface ipv4q_char_if import ipv4q_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface ipv4q_result_if import ipv4q_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             is_address;
	logic [LEN_W-1:0] scanned_length;

	modport source (output valid, output is_address, output scanned_length, input ready);
	modport sink (input valid, input is_address, input scanned_length, output ready);
endinterface

// File: rtl/core/ipv4q_in_stage.sv
// Input register: holds one character word until the scan can consume it.
module ipv4q_in_stage import ipv4q_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ipv4q_char_if.sink          chars,
	input  logic                out_free,
	output logic                advance,
	output char_t               item
);

	logic  valid_s1;
	char_t item_s1;

	// A word without the end mark never produces a result, so it never waits.
	assign advance     = valid_s1 && (!item_s1.last || out_free);
	assign chars.ready = !valid_s1 || advance;
	assign item        = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1.ch   <= chars.ch;
			item_s1.last <= chars.last;
		end
	end

endmodule

// File: rtl/core/ipv4q_scan.sv
// Scan state and the per-character update of the dotted-quad parser.
module ipv4q_scan import ipv4q_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  char_t   item,
	output result_t res
);

	logic [2:0]       octet_index_q, octet_index_d;
	logic [1:0]       digit_count_q, digit_count_d;
	logic [VAL_W-1:0] octet_value_q, octet_value_d;
	logic [POS_W-1:0] char_position_q, char_position_d;
	logic             expect_dot_q, expect_dot_d;
	logic             decided_q, decided_d;
	logic             verdict_q, verdict_d;
	logic [LEN_W-1:0] decided_length_q, decided_length_d;

	logic             is_digit;
	logic             closed;
	logic [LEN_W-1:0] pos_p1;
	logic [LEN_W-1:0] pos_p2;
	logic [VAL_W-1:0] digit_val;
	logic [VAL_W-1:0] acc_val;

	assign is_digit  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
	assign pos_p1    = {1'b0, char_position_q} + LEN_W'(1);
	assign pos_p2    = {1'b0, char_position_q} + LEN_W'(2);
	assign digit_val = VAL_W'(item.ch - CH_ZERO);
	// Times ten as two shifts; the octet holds at most two digits here.
	assign acc_val   = {octet_value_q[VAL_W-4:0], 3'b000}
		+ {octet_value_q[VAL_W-2:0], 1'b0} + digit_val;
	// The octet ends on a forced dot after three digits or on any non-digit.
	assign closed    = expect_dot_q || (!is_digit && digit_count_q != 2'd0);

	always_comb begin
		octet_index_d    = octet_index_q;
		digit_count_d    = digit_count_q;
		octet_value_d    = octet_value_q;
		char_position_d  = char_position_q;
		expect_dot_d     = expect_dot_q;
		decided_d        = decided_q;
		verdict_d        = verdict_q;
		decided_length_d = decided_length_q;

		if (!decided_q) begin
			if (closed) begin
				if (octet_index_q != LAST_OCTET) begin
					if (item.ch == CH_DOT) begin
						octet_index_d = octet_index_q + 3'd1;
						digit_count_d = 2'd0;
						octet_value_d = '0;
						expect_dot_d  = 1'b0;
					end else begin
						decided_d        = 1'b1;
						verdict_d        = 1'b0;
						decided_length_d = pos_p1;
					end
				end else if (item.ch == CH_DOT || is_digit) begin
					decided_d        = 1'b1;
					verdict_d        = 1'b0;
					decided_length_d = pos_p1;
				end else begin
					decided_d        = 1'b1;
					verdict_d        = 1'b1;
					decided_length_d = {1'b0, char_position_q};
				end
			end else if (is_digit) begin
				octet_value_d = acc_val;
				digit_count_d = digit_count_q + 2'd1;
				if (digit_count_d == MAX_DIGITS) begin
					if (acc_val > OCTET_MAX) begin
						decided_d        = 1'b1;
						verdict_d        = 1'b0;
						decided_length_d = item.last ? pos_p1 : pos_p2;
					end else begin
						expect_dot_d = 1'b1;
					end
				end
			end else begin
				// A non-digit where an octet should start.
				decided_d        = 1'b1;
				verdict_d        = 1'b0;
				decided_length_d = pos_p1;
			end
			if (!decided_d) begin
				char_position_d = pos_p1[POS_W-1:0];
			end
		end
	end

	always_comb begin
		if (decided_d) begin
			res.is_address     = verdict_d;
			res.scanned_length = decided_length_d;
		end else begin
			res.is_address     = (octet_index_d == LAST_OCTET) && (digit_count_d != 2'd0);
			res.scanned_length = pos_p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q    <= '0;
			digit_count_q    <= '0;
			octet_value_q    <= '0;
			char_position_q  <= '0;
			expect_dot_q     <= 1'b0;
			decided_q        <= 1'b0;
			verdict_q        <= 1'b0;
			decided_length_q <= '0;
		end else if (advance) begin
			if (item.last) begin
				octet_index_q    <= '0;
				digit_count_q    <= '0;
				octet_value_q    <= '0;
				char_position_q  <= '0;
				expect_dot_q     <= 1'b0;
				decided_q        <= 1'b0;
				verdict_q        <= 1'b0;
				decided_length_q <= '0;
			end else begin
				octet_index_q    <= octet_index_d;
				digit_count_q    <= digit_count_d;
				octet_value_q    <= octet_value_d;
				char_position_q  <= char_position_d;
				expect_dot_q     <= expect_dot_d;
				decided_q        <= decided_d;
				verdict_q        <= verdict_d;
				decided_length_q <= decided_length_d;
			end
		end
	end

endmodule

// File: rtl/core/ipv4q_out_stage.sv
// Result register: holds one result word until the sink takes it.
module ipv4q_out_stage import ipv4q_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  result_t          res,
	output logic             out_free,
	ipv4q_result_if.source   results
);

	logic    valid_q;
	result_t res_q;

	assign out_free               = !valid_q || results.ready;
	assign results.valid          = valid_q;
	assign results.is_address     = res_q.is_address;
	assign results.scanned_length = res_q.scanned_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: rtl/core/ipv4_dotted_quad_check.sv
// Top level of the streaming dotted-quad IPv4 address checker.
//
// The block reads a string one character word per cycle on the chars channel,
// with last marking the final character, and decides whether the string
// begins with a dotted-quad IPv4 address: four octets of one to three decimal
// digits, each no more than 255, separated by single dots, and followed by the
// end of the string or by a character that is neither a dot nor a digit.
// Exactly one result word leaves on the results channel for every string, after
// its last character. is_address is set on a match, and scanned_length then
// gives the length of the address; on a failure it gives the failing position
// plus one, capped at the string length. Characters after the decision point
// are consumed but do not affect the result. A character word can be taken in
// every cycle. The last character of a string waits in the input register while
// the parser computes the result and the scan state returns to its reset value.
// The result is loaded into the result register, which drives results.valid,
// once that register is free. The results channel may stall freely: the input
// register keeps taking words while a result waits, and only the last character
// of the next string is held until the result register is free.
`include "ipv4_dotted_quad_check_macros.svh"

module ipv4_dotted_quad_check import ipv4q_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ipv4q_char_if.sink     chars,
	ipv4q_result_if.source results
);

	logic    advance;
	logic    out_free;
	char_t   item;
	result_t res;

	ipv4q_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.out_free (out_free),
		.advance  (advance),
		.item     (item)
	);

	// The scan state moves one character forward on each advance and returns
	// to its reset value after a last character.
	ipv4q_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item),
		.res     (res)
	);

	ipv4q_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && item.last),
		.res      (res),
		.out_free (out_free),
		.results  (results)
	);

	// A string's end never overwrites a result that is still waiting.
	`IPV4Q_ASSERT_IMPL(a_no_overwrite, advance && item.last, !results.valid || results.ready, "result overwritten")

	// Only the end of a string loads a result.
	`IPV4Q_ASSERT_NEXT(a_no_spurious, !results.valid && !(advance && item.last), !results.valid, "result without end of string")

	// Every end of a string yields a result in the next cycle.
	`IPV4Q_ASSERT_NEXT(a_result_follows, advance && item.last, results.valid, "end of string gave no result")

	// A matched address is between seven and fifteen characters long.
	`IPV4Q_ASSERT_IMPL(a_match_len, results.valid && results.is_address, results.scanned_length >= 5'd7 && results.scanned_length <= 5'd15, "bad address length")

endmodule
